@@ src/sgs_pkg.sv @@
package sgs_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WEFF_W    = COL_W + 1;
   localparam int ROW_W     = 12;
   localparam int PIX_W     = 8;
   localparam int CFG_W     = 12;
   localparam int IMG_W_W   = 11;
   localparam int CSR_IDX_W = 1;
   localparam int GRAD_W    = 11;
   localparam int GSUM_W    = 12;
   localparam int CCOL_W    = 10;
   localparam int RSP_W     = 2 * GRAD_W + GSUM_W + ROW_W + CCOL_W;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   // position of one accepted pixel, as the kernel stage needs it
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  center_row;
      logic [CCOL_W-1:0] center_col;
      logic              produce;
      logic              last;
   } pos_type;

   // line store write: {two rows above, row above}
   typedef struct packed {
      logic               en;
      logic [COL_W-1:0]   addr;
      logic [2*PIX_W-1:0] data;
   } mem_wr_type;

endpackage

@@ src/sgs_ram.sv @@
module sgs_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sgs_position.sv @@
module sgs_position
   import sgs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 accept,
   input  logic                 frame_start,
   output pos_type              pos
);

   logic [IMG_W_W-1:0] width_ff, width_in;
   logic [ROW_W-1:0]   height_ff, height_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;

   logic [WEFF_W-1:0]  width_eff;
   logic [ROW_W-1:0]   height_eff;
   logic [COL_W-1:0]   col_pre, col_cur;
   logic [ROW_W-1:0]   row_pre, row_cur;
   logic [ROW_W:0]     row_bump, row_next;
   logic [WEFF_W-1:0]  col_next;

   always_comb begin
      if (32'(width_ff) > MAX_WIDTH) begin
         width_eff = WEFF_W'(MAX_WIDTH);
      end else if (width_ff < IMG_W_W'(3)) begin
         width_eff = WEFF_W'(3);
      end else begin
         width_eff = WEFF_W'(width_ff);
      end
      height_eff = (height_ff < ROW_W'(3)) ? ROW_W'(3) : height_ff;
   end

   // place the pixel: frame start, then wrap a position left beyond new bounds
   always_comb begin
      col_pre = frame_start ? '0 : col_ff;
      row_pre = frame_start ? '0 : row_ff;
      if (WEFF_W'(col_pre) >= width_eff) begin
         col_cur  = '0;
         row_bump = (ROW_W+1)'(row_pre) + (ROW_W+1)'(1);
      end else begin
         col_cur  = col_pre;
         row_bump = (ROW_W+1)'(row_pre);
      end
      row_cur = (row_bump >= (ROW_W+1)'(height_eff)) ? '0 : row_bump[ROW_W-1:0];

      col_next = WEFF_W'(col_cur) + WEFF_W'(1);
      row_next = (ROW_W+1)'(row_cur) + (ROW_W+1)'(1);
      if (col_next >= width_eff) begin
         col_in = '0;
         row_in = (row_next >= (ROW_W+1)'(height_eff)) ? '0 : row_next[ROW_W-1:0];
      end else begin
         col_in = col_next[COL_W-1:0];
         row_in = row_cur;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_wdata[IMG_W_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_wdata[ROW_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMG_W_W'(1024);
         height_ff <= ROW_W'(480);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_comb begin
      pos.col        = col_cur;
      pos.center_row = row_cur - ROW_W'(1);
      pos.center_col = CCOL_W'(col_cur - COL_W'(1));
      pos.produce    = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
      pos.last       = (row_cur == height_eff - ROW_W'(1))
                    && (WEFF_W'(col_cur) == width_eff - WEFF_W'(1));
   end

endmodule

@@ src/sgs_kernel.sv @@
module sgs_kernel
   import sgs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [PIX_W-1:0]   req_pixel,
   input  pos_type            pos,
   output logic               accept,
   input  logic [2*PIX_W-1:0] mem_rd_data,
   output mem_wr_type         mem_wr,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,
   output logic               rsp_tlast
);

   logic              s1_valid_ff, s1_valid_in;
   pos_type           s1_pos_ff;
   logic [PIX_W-1:0]  s1_px_ff;
   logic              fwd_ff, fwd_in;
   logic [PIX_W-1:0]  fwd_above_ff, fwd_two_ff;
   logic [PIX_W-1:0]  w0t_ff, w0m_ff, w0b_ff, w1t_ff, w1m_ff, w1b_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff;
   logic              rsp_last_ff;

   logic              s1_adv;
   logic [PIX_W-1:0]  above_eff, two_eff;
   logic [PIX_W+1:0]  top_sum, bot_sum, left_sum, right_sum;
   logic signed [GRAD_W-1:0] grad_h, grad_v;
   logic signed [GSUM_W-1:0] grad_s;

   assign s1_adv     = s1_valid_ff && (!s1_pos_ff.produce || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   // the line store misses a write made at the same edge as the read
   assign above_eff = fwd_ff ? fwd_above_ff : mem_rd_data[PIX_W-1:0];
   assign two_eff   = fwd_ff ? fwd_two_ff   : mem_rd_data[2*PIX_W-1:PIX_W];
   assign fwd_in    = s1_adv && (pos.col == s1_pos_ff.col);

   always_comb begin
      mem_wr.en   = s1_adv;
      mem_wr.addr = s1_pos_ff.col;
      mem_wr.data = {above_eff, s1_px_ff};
   end

   always_comb begin
      bot_sum   = (PIX_W+2)'(w0b_ff) + {1'b0, w1b_ff, 1'b0} + (PIX_W+2)'(s1_px_ff);
      top_sum   = (PIX_W+2)'(w0t_ff) + {1'b0, w1t_ff, 1'b0} + (PIX_W+2)'(two_eff);
      right_sum = (PIX_W+2)'(two_eff) + {1'b0, above_eff, 1'b0} + (PIX_W+2)'(s1_px_ff);
      left_sum  = (PIX_W+2)'(w0t_ff) + {1'b0, w0m_ff, 1'b0} + (PIX_W+2)'(w0b_ff);
      grad_h    = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
      grad_v    = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
      grad_s    = $signed({grad_h[GRAD_W-1], grad_h}) + $signed({grad_v[GRAD_W-1], grad_v});
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_adv && s1_pos_ff.produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         w0t_ff       <= '0;
         w0m_ff       <= '0;
         w0b_ff       <= '0;
         w1t_ff       <= '0;
         w1m_ff       <= '0;
         w1b_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fwd_ff <= fwd_in;
         end
         // shift the window one column on every completed pixel
         if (s1_adv) begin
            w0t_ff <= w1t_ff;
            w0m_ff <= w1m_ff;
            w0b_ff <= w1b_ff;
            w1t_ff <= two_eff;
            w1m_ff <= above_eff;
            w1b_ff <= s1_px_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff    <= pos;
         s1_px_ff     <= req_pixel;
         fwd_above_ff <= s1_px_ff;
         fwd_two_ff   <= above_eff;
      end
      if (s1_adv && s1_pos_ff.produce) begin
         rsp_data_ff <= {s1_pos_ff.center_col, s1_pos_ff.center_row, grad_s, grad_v, grad_h};
         rsp_last_ff <= s1_pos_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_stall_holds_read: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> $stable(mem_rd_data))
      else $error("line store read data changed while the stage was stalled");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(s1_adv && s1_pos_ff.produce))
      else $error("waiting result overwritten");

   a_write_from_valid: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |-> s1_valid_ff)
      else $error("line store written without a pixel in the stage");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_adv && s1_pos_ff.produce))
      else $error("result appeared without a producing pixel");

endmodule

@@ src/sobel_gradient_stream_top.sv @@
// The pixel is registered in the window stage, then its result in the result
// register that drives rsp_tvalid. Throughput: one pixel per cycle while the
// result side does not stall; the single line store port pair sustains it.
// Border pixels give no result; backpressure stalls interior pixels and the input.
// Reset (synchronous) clears the window, position counters and result register,
// and loads width 1024 and height 480; the line store is not cleared.
module sobel_gradient_stream_top
   import sgs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,  // [7:0] pixel
   input  logic                 req_tuser,  // [0] frame_start
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [10:0] grad_horizontal, [21:11] grad_vertical, [33:22] grad_sum,
   // [45:34] center_row, [55:46] center_col
   output logic [RSP_W-1:0]     rsp_tdata,
   output logic                 rsp_tlast,  // frame_last
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   pos_type            pos;
   logic               accept;
   logic [2*PIX_W-1:0] mem_rd_data;
   mem_wr_type         mem_wr;

   sgs_position u_position (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .frame_start (req_tuser),
      .pos         (pos)
   );

   sgs_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (2 * PIX_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (pos.col),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data)
   );

   sgs_kernel u_kernel (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_pixel   (req_tdata[PIX_W-1:0]),
      .pos         (pos),
      .accept      (accept),
      .mem_rd_data (mem_rd_data),
      .mem_wr      (mem_wr),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ bench/sobel_gradient_checker.sv @@
module sobel_gradient_checker
   import sgs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [7:0]           req_tdata,  // [7:0] pixel
   input  logic                 req_tuser,  // [0] frame_start
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [10:0] grad_horizontal, [21:11] grad_vertical, [33:22] grad_sum,
   // [45:34] center_row, [55:46] center_col
   input  logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 rsp_tlast,  // frame_last
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int                   mismatches,
   output int                   grads_pending,
   output int                   grads_checked,
   output int                   frames_closed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [GRAD_W-1:0] horiz;
      logic signed [GRAD_W-1:0] vert;
      logic signed [GSUM_W-1:0] sum;
      logic [ROW_W-1:0]         row;
      logic [CCOL_W-1:0]        col;
      logic                     last;
   } grad_type;

   grad_type expected_grads[$];

   logic [PIX_W-1:0]   row_above     [MAX_WIDTH] = '{default: '0};
   logic [PIX_W-1:0]   row_two_above [MAX_WIDTH] = '{default: '0};
   // two stored columns of the window: top, middle, bottom; oldest column first
   logic [PIX_W-1:0]   win [6];
   logic [IMG_W_W-1:0] width_reg;
   logic [ROW_W-1:0]   height_reg;
   int                 col_pos;
   int                 row_pos;

   // Place one pixel in the raster and return whether its window is interior.
   function automatic bit slide_window(input logic [PIX_W-1:0] px, input logic fs,
                                       output grad_type g);
      int w, h, c, r;
      int t0, t1, t2, m0, m2, b0, b1, b2;
      int gh, gv;
      bit interior;
      w = (width_reg < 3) ? 3 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
      h = (height_reg < 3) ? 3 : int'(height_reg);
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      // wrap lazily: a bound may have shrunk under the stored position
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h)
         row_pos = 0;
      c = col_pos;
      r = row_pos;
      t0 = win[0]; m0 = win[1]; b0 = win[2];
      t1 = win[3];              b1 = win[5];
      t2 = row_two_above[c];
      m2 = row_above[c];
      b2 = px;
      interior = (r >= 2) && (c >= 2);
      gh = (b0 + 2 * b1 + b2) - (t0 + 2 * t1 + t2);
      gv = (t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0);
      g.horiz = GRAD_W'(gh);
      g.vert  = GRAD_W'(gv);
      g.sum   = GSUM_W'(gh + gv);
      g.row   = ROW_W'(r - 1);
      g.col   = CCOL_W'(c - 1);
      g.last  = (r == h - 1) && (c == w - 1);
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = PIX_W'(t2);
      win[4] = PIX_W'(m2);
      win[5] = px;
      row_two_above[c] = row_above[c];
      row_above[c]     = px;
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h)
            row_pos = 0;
      end
      return interior;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      grad_type want;
      if (reset) begin
         width_reg  = IMG_W_W'(MAX_WIDTH);
         height_reg = ROW_W'(480);
         col_pos    = 0;
         row_pos    = 0;
         foreach (win[k])
            win[k] = '0;
         expected_grads.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_IMAGE_WIDTH:  width_reg  = csr_wdata[IMG_W_W-1:0];
               REG_IMAGE_HEIGHT: height_reg = csr_wdata[ROW_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (slide_window(req_tdata, req_tuser, want))
               expected_grads.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_grads.size() == 0) begin
               $error("gradient transfer with no interior pixel behind it");
               mismatches++;
            end else begin
               want = expected_grads.pop_front();
               check_field("grad_horizontal", int'(want.horiz),
                           int'($signed(rsp_tdata[GRAD_W-1:0])));
               check_field("grad_vertical", int'(want.vert),
                           int'($signed(rsp_tdata[2*GRAD_W-1:GRAD_W])));
               check_field("grad_sum", int'(want.sum),
                           int'($signed(rsp_tdata[2*GRAD_W+GSUM_W-1:2*GRAD_W])));
               check_field("center_row", int'(want.row),
                           int'(rsp_tdata[2*GRAD_W+GSUM_W+ROW_W-1:2*GRAD_W+GSUM_W]));
               check_field("center_col", int'(want.col),
                           int'(rsp_tdata[RSP_W-1:2*GRAD_W+GSUM_W+ROW_W]));
               check_field("frame_last", int'(want.last), int'(rsp_tlast));
               grads_checked++;
               if (rsp_tlast)
                  frames_closed++;
            end
         end
      end
      grads_pending = expected_grads.size();
   end

endmodule

@@ bench/tb_sobel_gradient_stream_top.sv @@
module tb_sobel_gradient_stream_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sgs_pkg::*;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_tvalid  = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata   = '0;
   logic                 req_tuser   = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready  = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = REG_IMAGE_WIDTH;
   logic [CFG_W-1:0]     csr_wdata   = '0;

   int mismatches;
   int grads_pending;
   int grads_checked;
   int frames_closed;

   int src_idle_pct = 0;
   int stall_pct    = 0;
   int hold_len     = 0;
   int hold_id      = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int pixels_sent  = 0;

   // three 3x3 frames in raster order: strongest upward edge, strongest
   // positive diagonal, strongest negative diagonal
   logic [7:0] patterns [3][9] = '{
      '{8'd255, 8'd255, 8'd255, 8'd128, 8'd128, 8'd128, 8'd0, 8'd0, 8'd0},
      '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255},
      '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0}
   };

   sobel_gradient_stream_top u_top (.*);

   sobel_gradient_checker u_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_id) begin
         hold_seen = hold_id;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      write_csr(REG_IMAGE_WIDTH, w);
      write_csr(REG_IMAGE_HEIGHT, h);
   endtask

   // valid stays high between back-to-back transfers
   task automatic offer_pixel(input logic [7:0] px, input logic fs);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= fs;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pixels_sent++;
   endtask

   task automatic send_run(input int n, input bit open_frame, input int restart_pct);
      logic [7:0] px;
      logic       fs;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) == 0)
            px = $urandom_range(1) ? 8'hFF : 8'h00;
         else
            px = 8'($urandom);
         fs = (i == 0 && open_frame) || ($urandom_range(99) < restart_pct);
         offer_pixel(px, fs);
      end
   endtask

   task automatic send_pattern(input int p, input bit open_frame);
      for (int i = 0; i < 9; i++)
         offer_pixel(patterns[p][i], open_frame && i == 0);
   endtask

   // drain all results, then let border pixels leave the pipeline
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (grads_pending != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_pace(input int src, input int sink);
      src_idle_pct = src;
      stall_pct    = sink;
   endtask

   initial begin
      int mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(3, 3);
      set_pace(0, 0);
      send_pattern(0, 1'b1);
      send_pattern(1, 1'b0);
      send_run(4, 1'b0, 0);
      send_pattern(2, 1'b1);
      wait_idle();

      // widths and heights below the minimum act as three
      configure(0, 1);
      set_pace(83, 0);
      send_run(60, 1'b1, 0);
      wait_idle();

      configure(8, 6);
      set_pace(0, 83);
      send_run(60, 1'b1, 2);
      wait_idle();

      configure(5, 4);
      set_pace(27, 27);
      send_run(60, 1'b1, 3);
      wait_idle();

      // hold the result side off so the block backs up into the input
      configure(13, 9);
      set_pace(0, 0);
      hold_len = 300;
      hold_id++;
      send_run(120, 1'b1, 1);
      wait_idle();

      // shrink the bounds under a frame in progress
      configure(12, 20);
      set_pace(27, 27);
      send_run(64, 1'b1, 0);
      wait_idle();
      write_csr(REG_IMAGE_WIDTH, 3);
      send_run(30, 1'b0, 0);
      wait_idle();
      write_csr(REG_IMAGE_HEIGHT, 4);
      send_run(40, 1'b0, 0);
      wait_idle();

      // oversized width clamps to the widest row, then the tallest frame
      configure(12'hFFF, 3);
      set_pace(0, 0);
      send_run(40, 1'b1, 0);
      wait_idle();
      configure(2, 12'hFFF);
      send_run(30, 1'b1, 0);
      wait_idle();

      for (int k = 0; k < 4; k++) begin
         configure(CFG_W'($urandom_range(16, 3)), CFG_W'($urandom_range(10, 3)));
         mode = $urandom_range(3);
         set_pace(mode == 1 ? 83 : (mode == 3 ? 27 : 0),
                  mode == 2 ? 83 : (mode == 3 ? 27 : 0));
         send_run(25, 1'b1, 4);
         wait_idle();
      end

      $display("Streamed %0d pixels, checked %0d gradient results, %0d frame ends",
               pixels_sent, grads_checked, frames_closed);
      $display("Small frames, clamped bounds, mid-frame bound changes, idles and stalls");
      if (mismatches == 0 && grads_pending == 0)
         $display("tb_sobel_gradient_stream_top OK");
      else
         $display("tb_sobel_gradient_stream_top NOT OK");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Run timed out");
      $display("tb_sobel_gradient_stream_top NOT OK");
      $finish;
   end

endmodule
